@@ hdl/rsg_pkg.sv @@
// Shared constants, types and arithmetic helpers for the subtractive generator seeding block.
package rsg_pkg;

    localparam int unsigned TAB_AW = 6;
    localparam int unsigned WORD_W = 30;
    localparam int unsigned SEED_W = 31;

    localparam logic [WORD_W-1:0] MOD_BIG     = 30'd1000000000;
    localparam logic [WORD_W-1:0] SEED_LIMIT  = 30'd161803398;
    localparam logic [TAB_AW-1:0] FILL_STRIDE = 6'd21;
    localparam logic [TAB_AW-1:0] TAB_LEN     = 6'd55;
    localparam logic [TAB_AW-1:0] MIX_SPLIT   = 6'd24;
    localparam logic [TAB_AW-1:0] MIX_FWD     = 6'd31;
    localparam logic [TAB_AW-1:0] FILL_STEPS  = 6'd54;
    localparam logic [1:0]        LAST_PASS   = 2'd3;

    typedef struct packed {
        logic              we;
        logic [TAB_AW-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic [TAB_AW-1:0] raddr_a;
        logic [TAB_AW-1:0] raddr_b;
    } t_ram_req;

    // (a - b) mod 10^9 for a, b below 10^9
    function automatic logic [WORD_W-1:0] sub_wrap(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
        logic [WORD_W:0] t;
        if (a >= b) begin
            t = {1'b0, a} - {1'b0, b};
        end else begin
            t = {1'b0, a} + {1'b0, MOD_BIG} - {1'b0, b};
        end
        return t[WORD_W-1:0];
    endfunction

    // Seed limit scaled by 2^k, for the restoring reduction
    function automatic logic [SEED_W-1:0] lim_shift(input logic [1:0] k);
        logic [SEED_W-1:0] l;
        l = {1'b0, SEED_LIMIT};
        return l << k;
    endfunction

    // Partner index of the mixing pass: 1 + (i + 30) mod 55
    function automatic logic [TAB_AW-1:0] mix_src(input logic [TAB_AW-1:0] i);
        if (i <= MIX_SPLIT) begin
            return i + MIX_FWD;
        end else begin
            return i - MIX_SPLIT;
        end
    endfunction

endpackage

@@ hdl/rsg_table_ram.sv @@
// Seed table memory: one write port, two registered read ports.
module rsg_table_ram (
    input  logic                      i_clk,
    input  rsg_pkg::t_ram_req         i_req,
    output logic [rsg_pkg::WORD_W-1:0] o_rd_a,
    output logic [rsg_pkg::WORD_W-1:0] o_rd_b
);
    import rsg_pkg::*;

    logic [WORD_W-1:0] mem [56];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        o_rd_a <= mem[i_req.raddr_a];
        o_rd_b <= mem[i_req.raddr_b];
    end

endmodule

@@ hdl/subtractive_rng_table_seeding_top.sv @@
// Top level of the subtractive generator table seeding block.
//
//  channel | dir | payload
//  --------+-----+--------------------------------------------------------------
//  s_axis  | in  | tdata[30:0] seed_value, one transfer per table rebuild
//  m_axis  | out | tdata[5:0] table_index, [35:6] table_word; tlast = last_word
//
//  One seed gives 55 output transfers. With the sink always ready an item runs
//  through 1 accept, 4 reduction steps, 55 fill writes, 220 mixing updates plus
//  1 drain, then a read, a load and a wait state per emitted word. The single
//  write port of the table memory sets the fill and mixing time. Reset (i_rst_n
//  low, synchronous) clears control only; the table holds garbage until the next
//  fill. A stalled sink holds the current word and pauses the emission walk.
module subtractive_rng_table_seeding_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [30:0] seed_value, [31] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [5:0] table_index, [35:6] table_word
    output logic        m_axis_tlast    // last_word
);
    import rsg_pkg::*;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_RED       = 4'd1;
    localparam logic [3:0] ST_FILL0     = 4'd2;
    localparam logic [3:0] ST_FILL      = 4'd3;
    localparam logic [3:0] ST_MIX       = 4'd4;
    localparam logic [3:0] ST_MIX_END   = 4'd5;
    localparam logic [3:0] ST_EMIT_RD   = 4'd6;
    localparam logic [3:0] ST_EMIT_LD   = 4'd7;
    localparam logic [3:0] ST_EMIT_WAIT = 4'd8;

    logic [3:0]        r_state, n_state;
    logic [SEED_W-1:0] r_seed;
    logic [1:0]        r_k;
    logic [WORD_W-1:0] r_prev, r_cur;
    logic [TAB_AW-1:0] r_pos, r_cnt, r_idx;
    logic [1:0]        r_pass;
    logic              r_wb_vld;
    logic [TAB_AW-1:0] r_wb_addr;
    logic              r_out_vld, r_out_last;
    logic [TAB_AW-1:0] r_out_idx;
    logic [WORD_W-1:0] r_out_word;

    t_ram_req          ram_req;
    logic [WORD_W-1:0] ram_rd_a, ram_rd_b;
    logic [WORD_W-1:0] fill_start;
    logic [TAB_AW:0]   pos_sum;
    logic              in_xfer, out_xfer;

    assign in_xfer    = s_axis_tvalid && s_axis_tready;
    assign out_xfer   = m_axis_tvalid && m_axis_tready;
    // Reduced seed is below 2^28; the chain starts at limit minus seed
    assign fill_start = SEED_LIMIT - {2'b00, r_seed[27:0]};
    assign pos_sum    = {1'b0, r_pos} + {1'b0, FILL_STRIDE};

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {4'b0000, r_out_word, r_out_idx};

    // Memory request: fill writes, mixing write-back in the cycle after its reads
    always_comb begin
        ram_req         = '0;
        ram_req.raddr_a = r_idx;
        ram_req.raddr_b = mix_src(r_idx);
        if (r_state == ST_FILL0) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = TAB_LEN;
            ram_req.wdata = fill_start;
        end else if (r_state == ST_FILL) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = r_pos;
            ram_req.wdata = r_cur;
        end else if (r_wb_vld) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = r_wb_addr;
            ram_req.wdata = sub_wrap(ram_rd_a, ram_rd_b);
        end
    end

    rsg_table_ram u_ram (
        .i_clk  (i_clk),
        .i_req  (ram_req),
        .o_rd_a (ram_rd_a),
        .o_rd_b (ram_rd_b)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (in_xfer) n_state = ST_RED;
            ST_RED:       if (r_k == 2'd0) n_state = ST_FILL0;
            ST_FILL0:     n_state = ST_FILL;
            ST_FILL:      if (r_cnt == FILL_STEPS) n_state = ST_MIX;
            ST_MIX:       if (r_idx == TAB_LEN && r_pass == LAST_PASS) n_state = ST_MIX_END;
            ST_MIX_END:   n_state = ST_EMIT_RD;
            ST_EMIT_RD:   n_state = ST_EMIT_LD;
            ST_EMIT_LD:   n_state = ST_EMIT_WAIT;
            ST_EMIT_WAIT: begin
                if (out_xfer) begin
                    n_state = (r_idx == TAB_LEN) ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wb_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_idx     <= 6'd1;
            r_pass    <= 2'd0;
            r_k       <= 2'd3;
            r_cnt     <= 6'd1;
        end else begin
            r_state  <= n_state;
            r_wb_vld <= (r_state == ST_MIX);
            case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_seed <= s_axis_tdata[SEED_W-1:0];
                        r_k    <= 2'd3;
                    end
                end
                ST_RED: begin
                    // Restoring reduction: conditional subtract of limit * 8, 4, 2, 1
                    if (r_seed >= lim_shift(r_k)) begin
                        r_seed <= r_seed - lim_shift(r_k);
                    end
                    r_k <= r_k - 2'd1;
                end
                ST_FILL0: begin
                    r_prev <= fill_start;
                    r_cur  <= 30'd1;
                    r_pos  <= FILL_STRIDE;
                    r_cnt  <= 6'd1;
                end
                ST_FILL: begin
                    // Walk the table in steps of 21 mod 55
                    r_cur  <= sub_wrap(r_prev, r_cur);
                    r_prev <= r_cur;
                    r_pos  <= (pos_sum >= {1'b0, TAB_LEN}) ? 6'(pos_sum - {1'b0, TAB_LEN})
                                                           : pos_sum[TAB_AW-1:0];
                    r_cnt  <= r_cnt + 6'd1;
                    r_idx  <= 6'd1;
                    r_pass <= 2'd0;
                end
                ST_MIX: begin
                    r_wb_addr <= r_idx;
                    if (r_idx == TAB_LEN) begin
                        r_idx  <= 6'd1;
                        r_pass <= r_pass + 2'd1;
                    end else begin
                        r_idx <= r_idx + 6'd1;
                    end
                end
                ST_EMIT_LD: begin
                    // Read data for r_idx is valid now; load the output register
                    r_out_vld  <= 1'b1;
                    r_out_idx  <= r_idx;
                    r_out_word <= ram_rd_a;
                    r_out_last <= (r_idx == TAB_LEN);
                end
                ST_EMIT_WAIT: begin
                    if (out_xfer) begin
                        r_out_vld <= 1'b0;
                        r_idx     <= (r_idx == TAB_LEN) ? 6'd1 : r_idx + 6'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Output is only presented while the emission walk waits on the sink
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_state == ST_EMIT_WAIT && r_out_idx != 6'd0))
        else $error("output valid outside emission");

    // The final transfer of a run frees the input side on the next cycle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && m_axis_tlast) |=> s_axis_tready)
        else $error("block not idle after last word");

    // Mixing write-back never touches the unused entry zero
    a_wb_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_vld |-> (r_wb_addr != 6'd0 && r_wb_addr <= TAB_LEN))
        else $error("write-back address out of range");

endmodule

@@ dv/tb_subtractive_rng_table_seeding_top.sv @@
// Self-checking testbench for the subtractive generator table seeding block.
module tb_subtractive_rng_table_seeding_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rsg_pkg::*;

    // Arithmetic of the seeding scheme, kept apart from the design's package
    localparam int unsigned WRAP_MOD     = 1000000000;
    localparam int unsigned REDUCE_MOD   = 161803398;
    localparam int unsigned WALK_STRIDE  = 21;
    localparam int unsigned WORDS        = 55;
    localparam int unsigned PARTNER_OFS  = 30;
    localparam int unsigned MIX_ROUNDS   = 4;

    // Longest stretch without any transfer before the run is declared hung
    localparam int unsigned STALL_LIMIT  = 6000;
    // Long sink hold-off that backs the block up into its input
    localparam int unsigned HOLDOFF_LEN  = 800;
    // Quiet cycles after the last word before the leftover check
    localparam int unsigned TAIL_CYCLES  = 60;

    // One emitted table word as the sink sees it
    typedef struct packed {
        logic [TAB_AW-1:0] idx;
        logic [WORD_W-1:0] word;
        logic              last;
    } t_table_word;

    // Predicts the 55 table words of each accepted seed and checks the stream
    class seed_table_scoreboard;
        t_table_word expected_words[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        // (a - b) modulo one billion, operands below one billion
        static function int unsigned wrap_sub(int unsigned a, int unsigned b);
            return (a >= b) ? a - b : (a + WRAP_MOD) - b;
        endfunction

        function void note_seed(logic [SEED_W-1:0] seed);
            int unsigned words [1:WORDS];
            int unsigned prev_val;
            int unsigned cur_val;
            int unsigned pos;
            int unsigned partner;
            t_table_word entry;
            prev_val = REDUCE_MOD - (int'(seed) % REDUCE_MOD);
            words[WORDS] = prev_val;
            cur_val = 1;
            // scatter the chain across the table in stride-21 order
            for (int unsigned i = 1; i < WORDS; i++) begin
                pos = (WALK_STRIDE * i) % WORDS;
                words[pos] = cur_val;
                cur_val = wrap_sub(prev_val, cur_val);
                prev_val = words[pos];
            end
            // mixing passes, each word minus its partner 31 places on
            for (int unsigned r = 0; r < MIX_ROUNDS; r++) begin
                for (int unsigned i = 1; i <= WORDS; i++) begin
                    partner = 1 + (i + PARTNER_OFS) % WORDS;
                    words[i] = wrap_sub(words[i], words[partner]);
                end
            end
            for (int unsigned i = 1; i <= WORDS; i++) begin
                entry.idx  = TAB_AW'(i);
                entry.word = WORD_W'(words[i]);
                entry.last = (i == WORDS);
                expected_words.push_back(entry);
            end
        endfunction

        task flag_mismatch(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        task check_word(logic [39:0] data, logic last);
            t_table_word want;
            logic [TAB_AW-1:0] got_idx;
            logic [WORD_W-1:0] got_word;
            got_idx  = data[TAB_AW-1:0];
            got_word = data[TAB_AW+WORD_W-1:TAB_AW];
            if (expected_words.size() == 0) begin
                flag_mismatch($sformatf("unexpected word, index %0d value %0d",
                                        got_idx, got_word));
                return;
            end
            want = expected_words.pop_front();
            if (got_idx !== want.idx)
                flag_mismatch($sformatf("table_index %0d, want %0d", got_idx, want.idx));
            if (got_word !== want.word)
                flag_mismatch($sformatf("table_word at %0d is %0d, want %0d",
                                        want.idx, got_word, want.word));
            if (last !== want.last)
                flag_mismatch($sformatf("last_word at %0d is %b, want %b",
                                        want.idx, last, want.last));
        endtask

        function int unsigned pending();
            return expected_words.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;     // [30:0] seed_value, [31] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;     // [5:0] table_index, [35:6] table_word
    logic        m_axis_tlast;     // last_word

    seed_table_scoreboard sb = new();

    // Idle and stall rates in percent, changed phase by phase
    int unsigned send_idle_pct;
    int unsigned sink_stall_pct;
    // Set by the stimulus to make the sink hold off for that many cycles
    int unsigned holdoff_request;
    int unsigned quiet_cycles;

    subtractive_rng_table_seeding_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Sink side: random stalls, or a counted hold-off when one is requested
    initial begin : sink_driver
        int unsigned holdoff_left;
        holdoff_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_request != 0) begin
                holdoff_left = holdoff_request;
                holdoff_request = 0;
            end
            if (holdoff_left != 0) begin
                m_axis_tready <= 1'b0;
                holdoff_left--;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    // Monitor: sample both channels at the edge, feed the scoreboard, and
    // watch for a hang. Values read here are the ones before the edge.
    initial begin : monitor
        logic moved;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            moved = 1'b0;
            if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
                sb.note_seed(s_axis_tdata[SEED_W-1:0]);
                moved = 1'b1;
            end
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                sb.check_word(m_axis_tdata, m_axis_tlast);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles, %0d words outstanding",
                         quiet_cycles, sb.pending());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Offer one seed, with an optional idle gap first; hold tvalid high until
    // the transfer so back-to-back seeds keep it asserted.
    task automatic send_seed(logic [SEED_W-1:0] seed);
        int unsigned gap;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, seed};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Drop tvalid and wait until every predicted word has been seen
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Seeds biased toward the interesting spots: small values, values around
    // multiples of the reduction modulus, and full-width random patterns.
    function automatic logic [SEED_W-1:0] pick_seed();
        int unsigned k;
        longint unsigned base;
        case ($urandom_range(0, 3))
            0: return SEED_W'($urandom_range(0, 300));
            1: begin
                k = $urandom_range(1, 13);
                base = longint'(k) * REDUCE_MOD + $urandom_range(0, 4);
                return SEED_W'(base - 2);
            end
            default: return SEED_W'($urandom());
        endcase
    endfunction

    task automatic random_seeds(int unsigned count);
        for (int unsigned n = 0; n < count; n++) send_seed(pick_seed());
    endtask

    initial begin : stimulus
        logic [SEED_W-1:0] directed [$];
        directed = '{
            31'd0,                  // zero seed, used as it is
            31'd1, 31'd2,
            31'd161803397,          // just under the modulus
            31'd161803398,          // reduces to zero
            31'd161803399,
            31'd323606795,
            31'd2103444174,         // largest multiple of the modulus
            31'd2103444175,
            31'h7FFFFFFF, 31'h7FFFFFFE,
            31'h55555555, 31'h2AAAAAAA,
            31'h40000000, 31'h3FFFFFFF,
            31'd100000000
        };

        send_idle_pct   = 0;
        sink_stall_pct  = 0;
        holdoff_request = 0;
        i_rst_n         <= 1'b0;
        s_axis_tvalid   <= 1'b0;
        s_axis_tdata    <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed seeds, full rate on both sides
        foreach (directed[n]) send_seed(directed[n]);
        wait_drain();

        // source gaps
        send_idle_pct = 55;
        random_seeds(30);

        // sink stalls, starting with a long hold-off so the block backs up
        send_idle_pct   = 0;
        sink_stall_pct  = 55;
        holdoff_request = HOLDOFF_LEN;
        random_seeds(30);
        wait_drain();

        // light idling on both sides
        send_idle_pct  = 6;
        sink_stall_pct = 6;
        random_seeds(30);

        // full rate again to close
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        random_seeds(24);

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.flag_mismatch($sformatf("%0d words never arrived", sb.pending()));

        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
